### rtl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

  localparam logic [2:0] OP_GET     = 3'd0;
  localparam logic [2:0] OP_PUT     = 3'd1;
  localparam logic [2:0] OP_REPLACE = 3'd2;
  localparam logic [2:0] OP_ADD     = 3'd3;
  localparam logic [2:0] OP_REMOVE  = 3'd4;

  localparam logic [10:0] THRESH_RESET = 11'd768;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] hash_word1;
    logic [63:0] hash_word2;
    logic [63:0] item_in;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] item_out;
    logic        accepted;
    logic        status;
    logic [10:0] live_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, set probe start
    logic rd;        // issue bucket read at probe address
    logic adv;       // step probe address
    logic commit;    // apply update and build response
    logic clr;       // clear sweep write
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic valid_op;   // op code in range and key nonzero
    logic hit_match;  // read bucket holds the key
    logic hit_empty;  // read bucket is empty
    logic last_probe; // probed every bucket
    logic clr_done;   // clear sweep at last bucket
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/lpht_ctrl.sv
`default_nettype none
module lpht_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  lpht_pkg::dp_sts_t     sts_i,
  output logic                  busy_o,
  output lpht_pkg::dp_cmd_t     cmd_o
);
  import lpht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.valid_op) begin
          cmd_o.rd = 1'b1;
          state_d = S_WAIT;
        end else begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WAIT: state_d = S_EVAL;
      S_EVAL: begin
        if (sts_i.hit_match || sts_i.hit_empty || sts_i.last_probe) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end else begin
          // advance and read next bucket
          cmd_o.adv = 1'b1;
          state_d = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/lpht_dp.sv
`default_nettype none
module lpht_dp #(
  parameter int SLOTS = 1024
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  lpht_pkg::req_t     req_i,
  input  wire                cfg_we_i,
  input  wire  [10:0]        cfg_wdata_i,
  input  lpht_pkg::dp_cmd_t  cmd_i,
  output lpht_pkg::dp_sts_t  sts_o,
  output logic               rsp_valid_o,
  output lpht_pkg::rsp_t     rsp_o
);
  import lpht_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [63:0] mem_h1 [SLOTS];
  logic [63:0] mem_h2 [SLOTS];
  logic [63:0] mem_v  [SLOTS];
  logic        mem_d  [SLOTS];

  req_t        req_q;
  logic [AW-1:0] pos_q, clr_q;
  logic [AW:0]   nprobe_q;
  logic [63:0] rh1_q, rh2_q, rv_q;
  logic        rd_q;
  logic [CW-1:0] claimed_q, live_q;
  logic [10:0] thresh_q;
  logic        found_q, accepted_q, status_q;
  logic [63:0] item_out_q;

  logic [AW-1:0] pos_nx;
  assign pos_nx = (pos_q == AW'(SLOTS - 1)) ? '0 : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      thresh_q <= THRESH_RESET;
    end else begin
      if (cfg_we_i) thresh_q <= cfg_wdata_i;
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
    end
  end

  logic match, empty, live, is_ins, can_claim;
  assign match = (rh1_q == req_q.hash_word1) && (rh2_q == req_q.hash_word2);
  assign empty = (rh1_q == '0) && (rh2_q == '0);
  assign live  = match && !rd_q;
  assign is_ins = (req_q.req_type == OP_PUT) || (req_q.req_type == OP_ADD);
  assign can_claim = empty && ({{(11 > CW ? 11 - CW : 0){1'b0}}, claimed_q} < 
                     {{(CW > 11 ? CW - 11 : 0){1'b0}}, thresh_q});

  assign sts_o.valid_op = (req_q.req_type <= OP_REMOVE) &&
                          ((req_q.hash_word1 != '0) || (req_q.hash_word2 != '0));
  assign sts_o.hit_match  = match;
  assign sts_o.hit_empty  = empty;
  assign sts_o.last_probe = (nprobe_q == (AW+1)'(SLOTS));
  assign sts_o.clr_done   = (clr_q == AW'(SLOTS - 1));

  // the last probed bucket still counts when it matches or is empty
  logic ok_hit;
  assign ok_hit = cmd_i.commit && sts_o.valid_op;

  // memory port: clear sweep, commit write, probe read
  logic        we;
  logic [63:0] wh1, wh2, wv;
  logic        wd;
  always_comb begin
    we = 1'b0; wh1 = rh1_q; wh2 = rh2_q; wv = rv_q; wd = rd_q;
    if (ok_hit) begin
      priority if (is_ins && live) begin
        we = (req_q.req_type == OP_PUT); wv = req_q.item_in;
      end else if (is_ins && match) begin
        we = 1'b1; wv = req_q.item_in; wd = 1'b0;
      end else if (is_ins && can_claim) begin
        we = 1'b1; wh1 = req_q.hash_word1; wh2 = req_q.hash_word2;
        wv = req_q.item_in; wd = 1'b0;
      end else if (req_q.req_type == OP_REPLACE && live) begin
        we = 1'b1; wv = req_q.item_in;
      end else if (req_q.req_type == OP_REMOVE && live) begin
        we = 1'b1; wd = 1'b1;
      end else begin
        we = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_h1[clr_q] <= '0;
      mem_h2[clr_q] <= '0;
      mem_d[clr_q]  <= 1'b0;
    end else if (we) begin
      mem_h1[pos_q] <= wh1;
      mem_h2[pos_q] <= wh2;
      mem_v[pos_q]  <= wv;
      mem_d[pos_q]  <= wd;
    end
    if (cmd_i.rd) begin
      rh1_q <= mem_h1[pos_q];
      rh2_q <= mem_h2[pos_q];
      rv_q  <= mem_v[pos_q];
      rd_q  <= mem_d[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_i;
      pos_q    <= req_i.hash_word2[AW-1:0];
      nprobe_q <= '0;
    end else if (cmd_i.rd) begin
      nprobe_q <= nprobe_q + 1'b1;
    end else if (cmd_i.adv) begin
      pos_q <= pos_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      claimed_q   <= '0;
      live_q      <= '0;
      rsp_valid_o <= 1'b0;
    end else begin
      rsp_valid_o <= cmd_i.commit;
      if (ok_hit && is_ins && !match && can_claim) claimed_q <= claimed_q + 1'b1;
      if (ok_hit && is_ins && match && rd_q) live_q <= live_q + 1'b1;
      else if (ok_hit && is_ins && !match && can_claim) live_q <= live_q + 1'b1;
      else if (ok_hit && req_q.req_type == OP_REMOVE && live) live_q <= live_q - 1'b1;
    end
  end

  // response fields, valid the cycle after commit
  logic lv, ins_ok;
  assign lv = sts_o.valid_op && match && !rd_q;
  assign ins_ok = sts_o.valid_op && is_ins && !lv && (match || can_claim);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      found_q    <= lv;
      item_out_q <= (lv && req_q.req_type != OP_ADD) ? rv_q : '0;
      accepted_q <= ins_ok && (req_q.req_type == OP_ADD);
      status_q   <= sts_o.valid_op && is_ins && !lv && !ins_ok;
    end
  end

  assign rsp_o = '{found:      found_q,
                   item_out:   item_out_q,
                   accepted:   accepted_q,
                   status:     status_q,
                   live_count: 11'(live_q)};
endmodule
`default_nettype wire

### rtl/linear_probe_hash_table.sv
// Flow: an accepted request walks the check, read wait and evaluate states for each
// probed bucket, then commits and registers its result; a zero key or unused code commits from check.
// Throughput: one request at a time; busy is high for the whole probe walk,
// set by the single read port of the bucket memory.
// Reset: clears counters, loads threshold 768, then sweeps every bucket, clearing
// the bucket store with busy high. Results are strobed one cycle; no stall.
`default_nettype none
module linear_probe_hash_table #(
  parameter int SLOTS = 1024
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  input  lpht_pkg::req_t   req_i,
  input  wire              cfg_we_i,
  input  wire  [10:0]      cfg_wdata_i,
  output logic             done_o,
  output lpht_pkg::rsp_t   rsp_o
);
  import lpht_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .busy_o(busy), .cmd_o(cmd)
  );

  lpht_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni, .req_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_i(cmd), .sts_o(sts), .rsp_valid_o(done_o), .rsp_o
  );
endmodule
`default_nettype wire

### sim/linear_probe_hash_table_tb.sv
`default_nettype none
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int NBUCKET    = 1024;
  localparam int WDOG_LIMIT = 20000;
  localparam int NPOOL      = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        done_o;
  rsp_t        rsp_o;

  linear_probe_hash_table #(.SLOTS(NBUCKET)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

  // shadow copy of the bucket store
  logic [63:0] shadow_hi [NBUCKET];
  logic [63:0] shadow_lo [NBUCKET];
  logic [63:0] shadow_val[NBUCKET];
  bit          shadow_del[NBUCKET];
  int          claimed_cnt;
  int          live_cnt;
  logic [10:0] fill_limit;

  req_t        request_q[$];
  rsp_t        expected_q[$];
  logic [63:0] pool_hi[NPOOL];
  logic [63:0] pool_lo[NPOOL];
  int          mismatches;
  int          burst_left;
  int          gap_left;
  int          idle_cycles;
  bit          start_nxt;

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int   pos;
    int   n;
    int   kind;   // 0 match, 1 empty, 2 none
    bit   is_live;
    o = '0;
    if (r.req_type <= OP_REMOVE && (r.hash_word1 != 0 || r.hash_word2 != 0)) begin
      pos  = int'(r.hash_word2[9:0]);
      kind = 2;
      for (n = 0; n < NBUCKET && kind == 2; n++) begin
        if (shadow_hi[pos] == r.hash_word1 && shadow_lo[pos] == r.hash_word2) kind = 0;
        else if (shadow_hi[pos] == 0 && shadow_lo[pos] == 0) kind = 1;
        else pos = (pos + 1) % NBUCKET;
      end
      if (kind == 2) pos = 0;
      is_live = (kind == 0) && !shadow_del[pos];
      if (is_live) begin
        o.found = 1'b1;
        if (r.req_type != OP_ADD) o.item_out = shadow_val[pos];
      end
      case (r.req_type)
        OP_PUT, OP_ADD: begin
          if (is_live) begin
            if (r.req_type == OP_PUT) shadow_val[pos] = r.item_in;
          end else if (kind == 0) begin
            shadow_val[pos] = r.item_in;
            shadow_del[pos] = 1'b0;
            live_cnt++;
            o.accepted = (r.req_type == OP_ADD);
          end else if (kind == 1 && claimed_cnt < fill_limit) begin
            shadow_hi[pos]  = r.hash_word1;
            shadow_lo[pos]  = r.hash_word2;
            shadow_val[pos] = r.item_in;
            shadow_del[pos] = 1'b0;
            claimed_cnt++;
            live_cnt++;
            o.accepted = (r.req_type == OP_ADD);
          end else begin
            o.status = 1'b1;
          end
        end
        OP_REPLACE: if (is_live) shadow_val[pos] = r.item_in;
        OP_REMOVE: if (is_live) begin
          shadow_del[pos] = 1'b1;
          live_cnt--;
        end
        default: ;
      endcase
    end
    o.live_count = live_cnt[10:0];
    return o;
  endfunction

  task automatic push_request(logic [2:0] op, logic [63:0] k1, logic [63:0] k2,
                              logic [63:0] item);
    req_t r;
    r.req_type   = op;
    r.hash_word1 = k1;
    r.hash_word2 = k2;
    r.item_in    = item;
    request_q.push_back(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_random();
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, NPOOL - 1);
    if (sel < 80)
      push_request(3'($urandom_range(0, 4)), pool_hi[k], pool_lo[k], rand64());
    else if (sel < 86)
      push_request(3'($urandom_range(5, 7)), pool_hi[k], pool_lo[k], rand64());
    else if (sel < 92)
      push_request(3'($urandom_range(0, 4)), '0, '0, rand64());
    else
      push_request(3'($urandom_range(0, 4)), rand64(), rand64(), rand64());
  endtask

  // hold until every request has come back, then write the threshold
  task automatic write_threshold(logic [10:0] v);
    while (request_q.size() != 0 || expected_q.size() != 0 || start || busy)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    fill_limit = v;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: bursts of requests with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      burst_left  = $urandom_range(1, 16);
      gap_left    = 0;
    end else begin
      start_nxt = start;
      if (start && !busy) begin
        expected_q.push_back(apply_request(req_i));
        void'(request_q.pop_front());
        start_nxt = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!start_nxt) begin
        if (gap_left > 0) gap_left--;
        else if (request_q.size() != 0) start_nxt = 1'b1;
      end
      start <= start_nxt;
      if (request_q.size() != 0) req_i <= request_q[0];
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp_o);
        mismatches++;
      end else begin
        if (rsp_o.found !== expected_q[0].found) begin
          $display("%0t: found exp %h got %h", $time, expected_q[0].found, rsp_o.found);
          mismatches++;
        end
        if (rsp_o.item_out !== expected_q[0].item_out) begin
          $display("%0t: item_out exp %h got %h", $time, expected_q[0].item_out,
                   rsp_o.item_out);
          mismatches++;
        end
        if (rsp_o.accepted !== expected_q[0].accepted) begin
          $display("%0t: accepted exp %h got %h", $time, expected_q[0].accepted,
                   rsp_o.accepted);
          mismatches++;
        end
        if (rsp_o.status !== expected_q[0].status) begin
          $display("%0t: status exp %h got %h", $time, expected_q[0].status, rsp_o.status);
          mismatches++;
        end
        if (rsp_o.live_count !== expected_q[0].live_count) begin
          $display("%0t: live_count exp %0d got %0d", $time, expected_q[0].live_count,
                   rsp_o.live_count);
          mismatches++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // watchdog: count cycles with no request and no result accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] ka1, ka2, kb1, kx1, kx2, v;
    mismatches  = 0;
    idle_cycles = 0;
    claimed_cnt = 0;
    live_cnt    = 0;
    fill_limit  = THRESH_RESET;
    for (int i = 0; i < NBUCKET; i++) begin
      shadow_hi[i]  = '0;
      shadow_lo[i]  = '0;
      shadow_del[i] = 1'b0;
    end
    // pool keys crowd a few start buckets so probes collide and wrap
    for (int i = 0; i < NPOOL; i++) begin
      pool_hi[i] = (i % 7 == 0) ? 64'd0 : rand64();
      pool_lo[i] = {54'(rand64() >> 10), 10'(1016 + $urandom_range(0, 15))};
      if (pool_hi[i] == 0 && pool_lo[i] == 0) pool_lo[i] = 64'd5;
    end
    ka1 = rand64() | 64'd1;
    ka2 = {54'(rand64() >> 10), 10'd1023};
    kb1 = ka1 ^ 64'h8000_0000_0000_0000;
    wait (rst_ni);

    push_request(OP_GET,     ka1, ka2, rand64());
    push_request(OP_PUT,     ka1, ka2, '0);
    push_request(OP_PUT,     ka1, ka2, '1);
    push_request(OP_REPLACE, ka1, ka2, 64'h5555_aaaa_0f0f_f0f0);
    push_request(OP_ADD,     ka1, ka2, rand64());
    push_request(OP_REMOVE,  ka1, ka2, rand64());
    push_request(OP_GET,     ka1, ka2, rand64());
    push_request(OP_REPLACE, ka1, ka2, rand64());
    push_request(OP_REMOVE,  ka1, ka2, rand64());
    push_request(OP_ADD,     ka1, ka2, 64'h1234_5678_9abc_def0);
    push_request(OP_PUT,     kb1, ka2, rand64());
    push_request(OP_GET,     kb1, ka2, rand64());
    push_request(OP_REMOVE,  kb1, ka2, rand64());
    push_request(OP_PUT,     kb1, ka2, '1);
    push_request(OP_PUT,     '0,  '0,  rand64());
    push_request(OP_ADD,     '0,  '0,  rand64());
    push_request(OP_GET,     '0,  '0,  rand64());
    push_request(3'd5,       ka1, ka2, rand64());
    push_request(3'd6,       ka1, ka2, rand64());
    push_request(3'd7,       ka1, ka2, rand64());
    push_request(OP_PUT,     '0,  '1,  rand64());
    push_request(OP_GET,     '0,  '1,  rand64());
    push_request(OP_ADD,     '1,  '0,  '1);
    push_request(OP_GET,     ka1, ka2, rand64());

    // zero threshold: refuse every new key, live keys still update
    write_threshold(11'd0);
    kx1 = rand64();
    kx2 = rand64();
    push_request(OP_PUT, kx1, kx2, rand64());
    push_request(OP_ADD, kx1, kx2, rand64());
    push_request(OP_PUT, ka1, ka2, rand64());

    write_threshold(11'd30);
    repeat (300) push_random();
    write_threshold(11'd1024);
    repeat (300) push_random();

    // pile keys onto one start bucket, then walk the long cluster past the wrap
    for (int i = 0; i < 64; i++)
      push_request(OP_PUT, rand64() | 64'd1, {54'(rand64() >> 10), 10'd1000}, rand64());
    v = rand64() | 64'd1;
    push_request(OP_GET, v, 64'd1000, rand64());
    push_request(OP_PUT, v, 64'd1000, rand64());
    push_request(OP_ADD, v, 64'd1000, rand64());

    while (request_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
